FILE: rtl/upe_pkg.sv
`default_nettype none

package upe_pkg;

    // Default number of runs that the queue between front and back can hold.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Most output beats that one input beat can cause.
    localparam int unsigned RUN_MAX = 3;

    // Width of the index of a beat inside a run.
    localparam int unsigned RUN_IDX_W = $clog2(RUN_MAX);

    // One run: the output beats caused by one input beat, in order.
    typedef struct packed {
        logic [RUN_IDX_W-1:0]        last_idx;
        logic [RUN_MAX-1:0][7:0]     bytes;
        logic [RUN_MAX-1:0]          stops;
    } run_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/uri_percent_unescaper_top.sv
// URI percent decoder, streaming one byte per beat.
//
// Input channel (in_valid / in_stall): one raw URI byte per beat, with
// is_last on the final byte of each URI. Output channel (out_valid /
// out_stall): decoded bytes, last_of_run on the final beat caused by one
// input beat, stopped on the question mark that ends decoding.
// Configuration: cfg_valid / cfg_ready write the two-bit mode register;
// cfg_ready is always high. Write it only while the block is idle.
//
// An accepted input beat is written into the run queue; the output register
// then loads its first output beat from the queue head. An input beat is
// taken every cycle while the run queue has room; the output register
// drains one beat a cycle while the receiver does not stall, so the queue
// absorbs the extra beats of an input beat that causes two or three. Beats
// that are held or dropped produce no output but are still taken.
// Reset clears the mode, the decoder phase and the queue. When the
// receiver stalls, the output beat holds, the queue fills, and in_stall
// rises once the queue is full.
`default_nettype none

module uri_percent_unescaper_top
#(
    parameter int unsigned QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             stopped
);

    upe_pkg::run_t           push_run;
    upe_pkg::run_t           head;
    upe_pkg::queue_status_t  q_status;
    logic                    push;
    logic                    pop;

    assign cfg_ready = 1'b1;

    // Front: classify each beat and build its run.
    upe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .q_status  (q_status),
        .in_stall  (in_stall),
        .push      (push),
        .run       (push_run)
    );

    // Queue of runs between front and back.
    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back: serialise runs into output beats.
    upe_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stopped     (stopped)
    );

`ifndef SYNTHESIS
    // A stop beat always carries a question mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> out_byte == 8'h3F)
        else $error("stop beat without question mark");

    // The stop beat is always the final beat of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped |-> last_of_run)
        else $error("stop beat not last of run");

    // The rest of a run is already queued, so no gap follows a mid-run beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a run");
`endif

endmodule

`default_nettype wire

FILE: rtl/upe_front.sv
`default_nettype none

module upe_front
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic [1:0]              cfg_data,
    input  wire logic                    in_valid,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    is_last,
    input  wire upe_pkg::queue_status_t  q_status,
    output logic                         in_stall,
    output logic                         push,
    output upe_pkg::run_t                run
);

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DEL  = 8'h7F;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic [1:0]  mode_reg;

    logic        accept;
    logic        in_dec;
    logic        in_hex;
    logic [7:0]  in_fold;
    logic [3:0]  nib_hi;
    logic [3:0]  nib_lo;
    logic [7:0]  dec_val;
    logic        do_plain;
    logic [1:0]  n;
    logic [7:0]  rb [upe_pkg::RUN_MAX];
    logic [upe_pkg::RUN_MAX-1:0] rs;

    // Character classes of the incoming byte.
    assign in_fold = in_byte | CH_SP;
    assign in_dec  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign in_hex  = in_dec || ((in_fold >= 8'h61) && (in_fold <= 8'h66));

    // Nibble values: a letter's low four bits are 1 to 6, so adding 9 gives 10 to 15.
    assign nib_hi  = ((held_reg >= 8'h30) && (held_reg <= 8'h39)) ?
                     held_reg[3:0] : held_reg[3:0] + 4'd9;
    assign nib_lo  = in_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
    assign dec_val = {nib_hi, nib_lo};

    assign accept   = in_valid && !q_status.full;
    assign in_stall = q_status.full;

    // Classify the beat and build the run of output bytes that it causes.
    always_comb
    begin
        n          = 2'd0;
        rs         = '0;
        phase_next = phase_reg;
        held_next  = held_reg;
        do_plain   = 1'b0;
        for (int i = 0; i < upe_pkg::RUN_MAX; i++)
        begin
            rb[i] = 8'h00;
        end

        case (phase_reg)
            PH_PLAIN:
            begin
                do_plain = 1'b1;
            end
            PH_PCT:
            begin
                if (in_hex && !is_last)
                begin
                    phase_next = PH_DIGIT;
                    held_next  = in_byte;
                end
                else
                begin
                    rb[n]    = CH_PCT;
                    n        = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (in_hex)
                begin
                    phase_next = PH_PLAIN;
                    if ((in_dec && !mode_reg[1]) ||
                        (!in_dec && (mode_reg[0] || !mode_reg[1]) &&
                         (dec_val != CH_QM || mode_reg == 2'd0)))
                    begin
                        // Plain decode.
                        rb[n] = dec_val;
                        n     = n + 2'd1;
                    end
                    else if (!in_dec && dec_val == CH_QM)
                    begin
                        // A decoded question mark ends decoding.
                        rb[n]      = CH_QM;
                        rs[n]      = 1'b1;
                        n          = n + 2'd1;
                        phase_next = PH_STOP;
                    end
                    else if (dec_val > CH_PCT && dec_val < CH_DEL)
                    begin
                        rb[n] = dec_val;
                        n     = n + 2'd1;
                    end
                    else
                    begin
                        // Redirect mode keeps out-of-range bytes escaped.
                        rb[0] = CH_PCT;
                        rb[1] = held_reg;
                        rb[2] = in_byte;
                        n     = 2'd3;
                    end
                end
                else
                begin
                    rb[0]    = CH_PCT;
                    rb[1]    = held_reg;
                    n        = 2'd2;
                    do_plain = 1'b1;
                end
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                phase_next = PH_PLAIN;
            end
        endcase

        // Plain-text handling of the current byte.
        if (do_plain)
        begin
            phase_next = PH_PLAIN;
            if (in_byte == CH_QM && mode_reg != 2'd0)
            begin
                rb[n]      = CH_QM;
                rs[n]      = 1'b1;
                n          = n + 2'd1;
                phase_next = PH_STOP;
            end
            else if (in_byte == CH_PCT && !is_last)
            begin
                phase_next = PH_PCT;
            end
            else if (in_byte == CH_PLUS)
            begin
                rb[n] = CH_SP;
                n     = n + 2'd1;
            end
            else
            begin
                rb[n] = in_byte;
                n     = n + 2'd1;
            end
        end

        // The end marker always returns to plain text.
        if (is_last)
        begin
            phase_next = PH_PLAIN;
            held_next  = 8'h00;
        end
        else if (phase_next != PH_DIGIT)
        begin
            held_next = 8'h00;
        end
    end

    // Pack the run for the queue.
    always_comb
    begin
        run.last_idx = n - 2'd1;
        run.stops    = rs;
        for (int i = 0; i < upe_pkg::RUN_MAX; i++)
        begin
            run.bytes[i] = rb[i];
        end
    end

    assign push = accept && (n != 2'd0);

    // Decoder state and the mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            held_reg  <= 8'h00;
            mode_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/upe_queue.sv
`default_nettype none

module upe_queue
#(
    parameter int unsigned DEPTH = upe_pkg::QUEUE_DEPTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire upe_pkg::run_t           push_run,
    input  wire logic                    pop,
    output upe_pkg::run_t                head,
    output upe_pkg::queue_status_t       status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    upe_pkg::run_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    // Run storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_run;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/upe_back.sv
`default_nettype none

module upe_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire upe_pkg::run_t           head,
    input  wire upe_pkg::queue_status_t  q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [7:0]                   out_byte,
    output logic                         last_of_run,
    output logic                         stopped
);

    logic [upe_pkg::RUN_IDX_W-1:0] idx_reg;
    logic                          valid_reg;
    logic [7:0]                    byte_reg;
    logic                          last_reg;
    logic                          stop_reg;
    logic                          load;
    logic                          take;
    logic                          at_end;

    assign load   = !valid_reg || !out_stall;
    assign take   = load && !q_status.empty;
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = take && at_end;

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign stopped     = stop_reg;

    // Output register, refilled one beat at a time from the head run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !q_status.empty;
            if (take)
            begin
                idx_reg <= at_end ? '0 : idx_reg + 1'b1;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= head.bytes[idx_reg];
            stop_reg <= head.stops[idx_reg];
            last_reg <= at_end;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_uri_percent_unescaper_top.sv
`timescale 1ns / 1ps

module tb_uri_percent_unescaper_top;

    // Mode bits and the characters that the decoder treats specially.
    localparam logic [1:0] MODE_PLAIN    = 2'b00;
    localparam logic [1:0] MODE_URI      = 2'b01;
    localparam logic [1:0] MODE_REDIRECT = 2'b10;
    localparam logic [1:0] MODE_BOTH     = 2'b11;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 150000;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_PCT_HELD,
        PH_DIGIT_HELD,
        PH_DROP
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } uri_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       stop;
    } dec_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = 2'b00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stopped;

    // Stimulus and checking state.
    uri_beat_t  pend_q[$];
    dec_beat_t  decoded_q[$];
    dec_beat_t  run_q[$];
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_arm = 1'b0;
    logic       hold_active = 1'b0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;

    // Predictor state.
    logic [1:0] dec_mode = MODE_PLAIN;
    dec_phase_t dec_phase = PH_TEXT;
    logic [7:0] held_digit = 8'h00;

    uri_percent_unescaper_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .stopped     (stopped)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Character classes of the escape syntax.
    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] b);
        logic [7:0] c;
        c = b | CASE_BIT;
        return c >= 8'h61 && c <= 8'h66;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || is_hex_letter(b);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] b);
        logic [7:0] c;
        if (is_digit(b))
        begin
            c = b - 8'h30;
        end
        else
        begin
            c = (b | CASE_BIT) - 8'h61 + 8'd10;
        end
        return c[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
        begin
            return 8'h30 + n;
        end
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    // Output beats of the input beat being decoded gather in run_q.
    function automatic void emit(input logic [7:0] ch, input logic stop);
        run_q.push_back('{ch: ch, run_end: 1'b0, stop: stop});
    endfunction

    function automatic void stop_at_qmark(input logic last);
        emit(CH_QMARK, 1'b1);
        dec_phase = last ? PH_TEXT : PH_DROP;
    endfunction

    function automatic void plain_text(input logic [7:0] b, input logic last);
        dec_phase = PH_TEXT;
        if (b == CH_QMARK && dec_mode != MODE_PLAIN)
        begin
            stop_at_qmark(last);
        end
        else if (b == CH_PCT && !last)
        begin
            dec_phase = PH_PCT_HELD;
        end
        else if (b == CH_PLUS)
        begin
            emit(CH_SPACE, 1'b0);
        end
        else
        begin
            emit(b, 1'b0);
        end
    endfunction

    // Redirect mode puts bytes outside the safe range back as an escape.
    function automatic void reescape(input logic [7:0] v, input logic [7:0] second);
        if (v > CH_PCT && v < CH_DEL)
        begin
            emit(v, 1'b0);
        end
        else
        begin
            emit(CH_PCT, 1'b0);
            emit(held_digit, 1'b0);
            emit(second, 1'b0);
        end
    endfunction

    function automatic void second_digit(input logic [7:0] b, input logic last);
        logic [7:0] v;
        v = {nibble(held_digit), nibble(b)};
        dec_phase = PH_TEXT;
        if (is_digit(b))
        begin
            if (dec_mode[1])
            begin
                reescape(v, b);
            end
            else
            begin
                emit(v, 1'b0);
            end
        end
        else if (dec_mode[0])
        begin
            if (v == CH_QMARK)
            begin
                stop_at_qmark(last);
            end
            else
            begin
                emit(v, 1'b0);
            end
        end
        else if (dec_mode[1])
        begin
            if (v == CH_QMARK)
            begin
                stop_at_qmark(last);
            end
            else
            begin
                reescape(v, b);
            end
        end
        else
        begin
            emit(v, 1'b0);
        end
    endfunction

    // Works out the output beats caused by one accepted input beat.
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        run_q.delete();
        case (dec_phase)
            PH_TEXT:
            begin
                plain_text(b, last);
            end
            PH_PCT_HELD:
            begin
                if (is_hex(b) && !last)
                begin
                    held_digit = b;
                    dec_phase = PH_DIGIT_HELD;
                end
                else
                begin
                    emit(CH_PCT, 1'b0);
                    plain_text(b, last);
                end
            end
            PH_DIGIT_HELD:
            begin
                if (is_hex(b))
                begin
                    second_digit(b, last);
                end
                else
                begin
                    emit(CH_PCT, 1'b0);
                    emit(held_digit, 1'b0);
                    plain_text(b, last);
                end
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            dec_phase = PH_TEXT;
            held_digit = 8'h00;
        end
        else if (dec_phase != PH_DIGIT_HELD)
        begin
            held_digit = 8'h00;
        end
        if (run_q.size() > 0)
        begin
            run_q[run_q.size() - 1].run_end = 1'b1;
        end
        foreach (run_q[i])
        begin
            decoded_q.push_back(run_q[i]);
        end
    endfunction

    // Input driver: a beat stays on the bus until it is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, is_last);
                void'(pend_q.pop_front());
            end
            if (!in_valid || !in_stall)
            begin
                if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= pend_q[0].ch;
                    is_last  <= pend_q[0].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, forced high during a long hold-off.
    always @(posedge clk)
    begin
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    // The long hold-off is timed here, apart from the main sequence.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
        end
    endfunction

    // Output monitor: each beat taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        dec_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected beat, expected none, got %02h last %b stop %b",
                         $time, out_byte, last_of_run, stopped);
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.ch, out_byte);
                check_field("last_of_run", {7'd0, want.run_end}, {7'd0, last_of_run});
                check_field("stopped", {7'd0, want.stop}, {7'd0, stopped});
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] ch, input logic last);
        pend_q.push_back('{ch: ch, last: last});
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_beat(s[i], i == s.len() - 1);
        end
    endtask

    // Builds one URI from random tokens; mostly valid escapes and text,
    // with broken escapes and arbitrary bytes mixed in.
    task automatic queue_uri(input int n_tok, inout int sent);
        logic [7:0] txt[$];
        logic [7:0] v;
        logic [7:0] b;
        int         kind;
        for (int t = 0; t < n_tok; t++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                v = 8'($urandom_range(8'h7e, 8'h21));
                txt.push_back(v);
            end
            else if (kind < 60)
            begin
                v = ($urandom_range(4) == 0) ? CH_QMARK : 8'($urandom_range(255));
                txt.push_back(CH_PCT);
                txt.push_back(hex_char(v[7:4], 1'($urandom_range(1))));
                txt.push_back(hex_char(v[3:0], 1'($urandom_range(1))));
            end
            else if (kind < 68)
            begin
                txt.push_back(CH_PLUS);
            end
            else if (kind < 75)
            begin
                txt.push_back(CH_QMARK);
            end
            else if (kind < 88)
            begin
                txt.push_back(CH_PCT);
                if ($urandom_range(1) == 0)
                begin
                    txt.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                end
                if ($urandom_range(2) != 0)
                begin
                    do
                    begin
                        b = 8'($urandom_range(255));
                    end
                    while (is_hex(b));
                    txt.push_back(b);
                end
            end
            else
            begin
                v = 8'($urandom_range(255));
                txt.push_back(v);
            end
        end
        foreach (txt[i])
        begin
            push_beat(txt[i], i == txt.size() - 1);
        end
        sent += txt.size();
    endtask

    // Returns once every beat is taken, every prediction met and the block drained.
    task automatic wait_idle();
        while (pend_q.size() != 0 || in_valid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        dec_mode = m;
    endtask

    task automatic run_phase(input logic [1:0] m, input int idle, input int stall,
                             input int n_items);
        int sent;
        sent = 0;
        write_mode(m);
        idle_pct  <= idle;
        stall_pct <= stall;
        while (sent < n_items)
        begin
            queue_uri($urandom_range(10, 1), sent);
        end
        wait_idle();
    endtask

    // Main sequence.
    initial
    begin
        int sent;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode: lone percent at the end, broken escapes, plus sign,
        // byte extremes and a question mark that does not stop.
        queue_text("%");
        queue_text("%zA+");
        queue_text("%4");
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b1);
        queue_text("%4g?");
        wait_idle();

        // Both bits set: letter second digit stops at a decoded question
        // mark and drops the rest; decimal second digit is re-escaped.
        write_mode(MODE_BOTH);
        queue_text("%3Fxy");
        queue_text("%0a%80");
        wait_idle();

        // Random URIs under each mode and idling pattern.
        run_phase(MODE_URI, 0, 0, 50);
        run_phase(MODE_REDIRECT, 86, 0, 45);
        run_phase(MODE_PLAIN, 0, 86, 45);
        run_phase(MODE_BOTH, 19, 19, 45);

        // Receiver holds off while the sender keeps offering beats.
        write_mode(MODE_REDIRECT);
        idle_pct  <= 0;
        stall_pct <= 0;
        hold_arm  <= 1'b1;
        sent = 0;
        while (sent < 40)
        begin
            queue_uri($urandom_range(10, 1), sent);
        end
        wait_idle();

        if (err_cnt == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/upe_pkg.sv
rtl/upe_front.sv
rtl/upe_queue.sv
rtl/upe_back.sv
rtl/uri_percent_unescaper_top.sv
verif/tb_uri_percent_unescaper_top.sv
